// ===== hw/rtl/dmlf_pkg.sv =====
// Shared types, constants and mode codes for the vertical min/max deinterlace filter.
`timescale 1ns / 1ps
`default_nettype none

package dmlf_pkg;

    // Default line store depth and row count range.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Field widths fixed by the stream format.
    localparam int PIX_W    = 24;
    localparam int CHAN_W   = 8;
    localparam int NCHAN    = 3;
    localparam int POS_W    = 11;
    localparam int OUT_W    = 2 * POS_W + PIX_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam int MODE_W   = 2;

    // Mode register codes.
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEEP   = 2'd2;

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [OUT_BYTES_W-1:0] t_out_data;

    // Neighborhood of one checked odd-row pixel.
    typedef struct packed {
        t_pixel upper_prev;   // even row above, column x
        t_pixel upper;        // even row above, column x+1
        t_pixel lower_prev;   // even row below, column x
        t_pixel lower;        // even row below, column x+1
        t_pixel center;       // odd-row pixel at column x
    } t_nbhd;

    // Verdict of the clamp check.
    typedef struct packed {
        logic   bad;
        t_pixel avg;
    } t_clamp;

endpackage

`default_nettype wire

// ===== hw/rtl/dmlf_clamp.sv =====
// Per-channel min/max range check and vertical floor average.
`timescale 1ns / 1ps
`default_nettype none

module dmlf_clamp (
    input  dmlf_pkg::t_nbhd  i_nbhd,
    output dmlf_pkg::t_clamp o_res
);
    import dmlf_pkg::*;

    // Each channel is independent: a four-way min and max, a range test
    // and the average of the pixels straight above and below.
    always_comb begin
        logic [CHAN_W-1:0] a0, a1, b0, b1, v, lo, hi;
        logic [CHAN_W:0]   sum;
        o_res = '0;
        for (int k = 0; k < NCHAN; k++) begin
            a0 = i_nbhd.upper_prev[k*CHAN_W +: CHAN_W];
            a1 = i_nbhd.upper[k*CHAN_W +: CHAN_W];
            b0 = i_nbhd.lower_prev[k*CHAN_W +: CHAN_W];
            b1 = i_nbhd.lower[k*CHAN_W +: CHAN_W];
            v  = i_nbhd.center[k*CHAN_W +: CHAN_W];
            lo = (a0 < a1) ? a0 : a1;
            lo = (lo < b0) ? lo : b0;
            lo = (lo < b1) ? lo : b1;
            hi = (a0 > a1) ? a0 : a1;
            hi = (hi > b0) ? hi : b0;
            hi = (hi > b1) ? hi : b1;
            if (v < lo || v > hi) begin
                o_res.bad = 1'b1;
            end
            sum = {1'b0, a0} + {1'b0, b0};
            o_res.avg[k*CHAN_W +: CHAN_W] = sum[CHAN_W:1];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/deinterlace_minmax_line_filter.sv =====
// Top level of the vertical min/max deinterlace filter with its two line stores.
//
//  Channel   Direction  Handshake                     Contents
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  pixel, end of line, end of frame
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  column, row, new value
//  cfg       in         i_cfg_valid/o_cfg_ready          mode register
//
//  One pixel word is taken every cycle unless the check stage is held; a rewrite
//  passes the check stage and the output register. Both line stores are read-first
//  RAMs read when a word is accepted, each written on rows of its own parity; the
//  registered read data feeds the check stage. Reset clears the counters, the mode
//  (to leave-unchanged) and the pipeline; the line stores are not cleared. A stalled
//  output holds one rewrite; one more rewrite in the check stage stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module deinterlace_minmax_line_filter #(
    parameter int MAX_WIDTH  = dmlf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dmlf_pkg::MAX_HEIGHT_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  dmlf_pkg::t_pixel        i_s_axis_tdata,   // [23:0] pixel
    input  wire                     i_s_axis_tlast,   // end of line
    input  wire                     i_s_axis_tuser,   // [0] end of frame
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    output dmlf_pkg::t_out_data     o_m_axis_tdata,   // [10:0] column, [21:11] row,
                                                      // [45:22] new value, [47:46] zero
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  dmlf_pkg::t_mode         i_cfg_data        // [1:0] mode
);
    import dmlf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Configuration
    t_mode r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_KEEP;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Raster position of the next pixel.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          w_acc;

    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_col = (r_col == CW'(MAX_WIDTH - 1)) ? '0 : r_col + 1'b1;
        n_row = r_row;
        if (i_s_axis_tuser) begin
            n_col = '0;
            n_row = '0;
        end else if (i_s_axis_tlast) begin
            n_col = '0;
            n_row = (r_row == RW'(MAX_HEIGHT - 1)) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores. Reads return the old entry, so an even pixel replaces its
    // own upper neighbor in the same cycle, and every later read sees all
    // earlier writes.
    t_pixel        r_even_mem [MAX_WIDTH];
    t_pixel        r_odd_mem  [MAX_WIDTH];
    t_pixel        r_even_rd;
    t_pixel        r_odd_rd;
    logic [CW-1:0] w_odd_raddr;

    assign w_odd_raddr = r_col - 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_even_rd <= r_even_mem[r_col];
            if (!r_row[0]) begin
                r_even_mem[r_col] <= i_s_axis_tdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_odd_rd <= r_odd_mem[w_odd_raddr];
            if (r_row[0]) begin
                r_odd_mem[r_col] <= i_s_axis_tdata;
            end
        end
    end

    // Check stage: the word whose store reads are now available.
    logic          r_s1_valid;
    logic          r_s1_odd;
    logic          r_s1_chk;
    t_mode         r_s1_mode;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    t_pixel        r_s1_pix;
    t_pixel        r_prev_upper;
    t_pixel        r_prev_lower;
    t_nbhd         w_nbhd;
    t_clamp        w_clamp;
    logic          w_s1_emit;
    logic          w_s1_adv;
    logic          w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_odd  <= r_row[0];
            r_s1_chk  <= (r_row > RW'(1)) && (r_col > CW'(1));
            r_s1_mode <= r_mode;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_pix  <= i_s_axis_tdata;
        end
    end

    assign w_nbhd = '{upper_prev: r_prev_upper, upper: r_even_rd,
                      lower_prev: r_prev_lower, lower: r_s1_pix,
                      center: r_odd_rd};

    dmlf_clamp u_clamp (
        .i_nbhd (w_nbhd),
        .o_res  (w_clamp)
    );

    assign w_s1_emit = r_s1_odd ? (r_s1_mode == MODE_DOUBLE)
                                : (r_s1_mode == MODE_CLAMP && r_s1_chk && w_clamp.bad);
    assign w_out_free      = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_s1_adv        = r_s1_valid && (!w_s1_emit || w_out_free);
    assign o_s_axis_tready = !r_s1_valid || w_s1_adv;

    // Even-row history for the next check: the old upper entry and the new
    // pixel at the column just retired.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_upper <= '0;
            r_prev_lower <= '0;
        end else if (w_s1_adv && !r_s1_odd) begin
            r_prev_upper <= r_even_rd;
            r_prev_lower <= r_s1_pix;
        end
    end

    // Output register.
    t_out_data n_out_data;

    always_comb begin
        if (r_s1_odd) begin
            n_out_data = {{(OUT_BYTES_W - OUT_W){1'b0}}, r_even_rd,
                          POS_W'(r_s1_row), POS_W'(r_s1_col)};
        end else begin
            n_out_data = {{(OUT_BYTES_W - OUT_W){1'b0}}, w_clamp.avg,
                          POS_W'(r_s1_row - 1'b1), POS_W'(r_s1_col - 1'b1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (w_s1_adv && w_s1_emit) begin
            o_m_axis_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            o_m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_s1_emit) begin
            o_m_axis_tdata <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dmlf_checker.sv =====
// Port-level checks for the deinterlace filter and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module dmlf_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_axis_tvalid,
    input wire                  o_s_axis_tready,
    input wire                  o_m_axis_tvalid,
    input wire                  i_m_axis_tready,
    input dmlf_pkg::t_out_data  o_m_axis_tdata
);
    import dmlf_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // A waiting rewrite holds its word until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("rewrite word changed or dropped while stalled");

    // Only odd rows are ever rewritten.
    a_odd_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[POS_W])
        else $error("rewrite addressed to an even row");

    // A fresh rewrite traces back to an accepted pixel word.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_in_acc, 2))
        else $error("rewrite appeared without a matching pixel");

    // The pad bits above the new value stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[OUT_BYTES_W-1:OUT_W] == '0)
        else $error("pad bits of the rewrite word are not zero");

endmodule

bind deinterlace_minmax_line_filter dmlf_checker u_dmlf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/dmlf_rewrite_checker.sv =====
// Checker that predicts the odd-row rewrites of the deinterlace filter and compares them.
`timescale 1ns / 1ps

module dmlf_rewrite_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_pix_valid,
    input  wire                  i_pix_ready,
    input  dmlf_pkg::t_pixel     i_pix_data,
    input  wire                  i_pix_eol,
    input  wire                  i_pix_eof,
    input  wire                  i_rw_valid,
    input  wire                  i_rw_ready,
    input  dmlf_pkg::t_out_data  i_rw_data,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  dmlf_pkg::t_mode      i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int LINE_DEPTH = dmlf_pkg::MAX_WIDTH_DEF;
    localparam int POS_W      = dmlf_pkg::POS_W;
    localparam int OUT_W      = dmlf_pkg::OUT_W;
    localparam int BYTES_W    = dmlf_pkg::OUT_BYTES_W;

    typedef struct packed {
        dmlf_pkg::t_pos   column;
        dmlf_pkg::t_pos   row;
        dmlf_pkg::t_pixel value;
    } t_rewrite;

    // Line stores and raster position. Both limits are 2048, so the 11-bit
    // positions wrap exactly where the block's counters do.
    dmlf_pkg::t_pixel even_row_mem [LINE_DEPTH];
    dmlf_pkg::t_pixel odd_row_mem  [LINE_DEPTH];
    dmlf_pkg::t_pos   col_pos;
    dmlf_pkg::t_pos   row_pos;
    dmlf_pkg::t_pixel left_upper;
    dmlf_pkg::t_pixel left_lower;
    dmlf_pkg::t_mode  mode_reg;
    t_rewrite         rewrites_due [$];

    // Work out the rewrite, if any, that one accepted pixel word causes.
    task automatic predict_rewrite(input dmlf_pkg::t_pixel pix, input logic eol,
                                   input logic eof);
        dmlf_pkg::t_pixel above;
        dmlf_pkg::t_pixel center;
        dmlf_pkg::t_pixel avg;
        dmlf_pkg::t_pixel nbr [4];
        logic [7:0]       lo;
        logic [7:0]       hi;
        logic [7:0]       ch;
        logic [8:0]       sum;
        logic             outside;
        t_rewrite         rw;
        if (row_pos[0]) begin
            // Odd row: store it; line doubling copies the pixel above.
            odd_row_mem[col_pos] = pix;
            if (mode_reg == dmlf_pkg::MODE_DOUBLE) begin
                rw.column = col_pos;
                rw.row    = row_pos;
                rw.value  = even_row_mem[col_pos];
                rewrites_due.push_back(rw);
            end
        end else begin
            above = even_row_mem[col_pos];
            // The odd pixel one column back is checked once its 2x2 window is complete.
            if (mode_reg == dmlf_pkg::MODE_CLAMP && row_pos >= 2 && col_pos >= 2) begin
                center  = odd_row_mem[col_pos - 1'b1];
                nbr[0]  = left_upper;
                nbr[1]  = above;
                nbr[2]  = left_lower;
                nbr[3]  = pix;
                outside = 1'b0;
                for (int k = 0; k < dmlf_pkg::NCHAN; k++) begin
                    lo = 8'hFF;
                    hi = 8'h00;
                    for (int j = 0; j < 4; j++) begin
                        ch = nbr[j][8*k +: 8];
                        if (ch < lo) lo = ch;
                        if (ch > hi) hi = ch;
                    end
                    if (center[8*k +: 8] < lo || center[8*k +: 8] > hi) outside = 1'b1;
                    sum = {1'b0, left_upper[8*k +: 8]} + {1'b0, left_lower[8*k +: 8]};
                    avg[8*k +: 8] = sum[8:1];
                end
                if (outside) begin
                    rw.column = col_pos - 1'b1;
                    rw.row    = row_pos - 1'b1;
                    rw.value  = avg;
                    rewrites_due.push_back(rw);
                end
            end
            left_upper            = above;
            left_lower            = pix;
            even_row_mem[col_pos] = pix;
        end

        // End of frame wins over end of line.
        if (eof) begin
            col_pos = '0;
            row_pos = '0;
        end else if (eol) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // Compare one rewrite word from the block with the oldest prediction.
    task automatic check_rewrite(input dmlf_pkg::t_out_data word);
        t_rewrite         want;
        dmlf_pkg::t_pos   got_col;
        dmlf_pkg::t_pos   got_row;
        dmlf_pkg::t_pixel got_val;
        got_col = word[POS_W-1:0];
        got_row = word[2*POS_W-1:POS_W];
        got_val = word[OUT_W-1:2*POS_W];
        if (word[BYTES_W-1:OUT_W] != '0) begin
            $error("padding: expected 0, got %0h", word[BYTES_W-1:OUT_W]);
            o_errors++;
        end
        if (rewrites_due.size() == 0) begin
            $error("rewrite at column %0d row %0d value %06h with none predicted",
                   got_col, got_row, got_val);
            o_errors++;
        end else begin
            want = rewrites_due.pop_front();
            o_checked++;
            if (got_col != want.column) begin
                $error("column: expected %0d, got %0d", want.column, got_col);
                o_errors++;
            end
            if (got_row != want.row) begin
                $error("row: expected %0d, got %0d", want.row, got_row);
                o_errors++;
            end
            if (got_val != want.value) begin
                $error("new_value: expected %06h, got %06h", want.value, got_val);
                o_errors++;
            end
        end
    endtask

    // Watch the three channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_DEPTH; i++) begin
                even_row_mem[i] = '0;
                odd_row_mem[i]  = '0;
            end
            col_pos    = '0;
            row_pos    = '0;
            left_upper = '0;
            left_lower = '0;
            mode_reg   = dmlf_pkg::MODE_KEEP;
            rewrites_due.delete();
            o_errors   = 0;
            o_checked  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) mode_reg = i_cfg_data;
            if (i_pix_valid && i_pix_ready) predict_rewrite(i_pix_data, i_pix_eol, i_pix_eof);
            if (i_rw_valid && i_rw_ready) check_rewrite(i_rw_data);
        end
        o_pending = rewrites_due.size();
    end

endmodule

// ===== tb/sv/tb_deinterlace_minmax_line_filter.sv =====
// Testbench top for the deinterlace filter: pixel stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_deinterlace_minmax_line_filter;

    localparam int LINE_MAX     = dmlf_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_WORDS = 920;
    localparam int CALM_FROM    = 780;
    localparam int DRAIN_CYCLES = 8;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                pix_valid = 1'b0;
    dmlf_pkg::t_pixel    pix_data  = '0;
    logic                pix_eol   = 1'b0;
    logic                pix_eof   = 1'b0;
    logic                rw_ready  = 1'b0;
    logic                cfg_valid = 1'b0;
    dmlf_pkg::t_mode     cfg_data  = dmlf_pkg::MODE_KEEP;
    logic                pix_ready;
    logic                rw_valid;
    dmlf_pkg::t_out_data rw_data;
    logic                cfg_ready;
    int                  mismatches;
    int                  rewrites_left;
    int                  rewrites_checked;

    // Flow-control knobs and a mirror of the raster position for legal row lengths.
    int                  src_gap_pct   = 0;
    int                  snk_stall_pct = 0;
    int                  stall_left    = 0;
    int                  words_sent    = 0;
    int                  frames_sent   = 0;
    int                  mode_writes   = 0;
    int                  even_cover    = 0;
    int                  odd_cover     = 0;
    dmlf_pkg::t_pos      col_at        = '0;
    dmlf_pkg::t_pos      row_at        = '0;

    always #10 clk = ~clk;

    deinterlace_minmax_line_filter DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (pix_valid),
        .o_s_axis_tready (pix_ready),
        .i_s_axis_tdata  (pix_data),
        .i_s_axis_tlast  (pix_eol),
        .i_s_axis_tuser  (pix_eof),
        .o_m_axis_tvalid (rw_valid),
        .i_m_axis_tready (rw_ready),
        .o_m_axis_tdata  (rw_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    dmlf_rewrite_checker rewrite_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix_valid (pix_valid),
        .i_pix_ready (pix_ready),
        .i_pix_data  (pix_data),
        .i_pix_eol   (pix_eol),
        .i_pix_eof   (pix_eof),
        .i_rw_valid  (rw_valid),
        .i_rw_ready  (rw_ready),
        .i_rw_data   (rw_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (mismatches),
        .o_pending   (rewrites_left),
        .o_checked   (rewrites_checked)
    );

    // Rewrite receiver: stalls in bursts that start at random with the set percentage.
    always @(negedge clk) begin
        if (stall_left == 0 && snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct)
            stall_left = $urandom_range(1, 10);
        if (stall_left != 0) begin
            rw_ready <= 1'b0;
            stall_left--;
        end else begin
            rw_ready <= 1'b1;
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #40_000_000;
        $display("Timeout after %0d pixel words", words_sent);
        $display("[deinterlace_minmax_line_filter] ERROR");
        $finish;
    end

    // Pixel content: fully random, smooth around a base color, or channels at 00/FF.
    function automatic dmlf_pkg::t_pixel make_pixel(input int style,
                                                    input dmlf_pkg::t_pixel base);
        dmlf_pkg::t_pixel p;
        logic [8:0]       v;
        p = dmlf_pkg::t_pixel'($urandom());
        for (int k = 0; k < dmlf_pkg::NCHAN; k++) begin
            if (style == 1) begin
                v = {1'b0, base[8*k +: 8]} + 9'($urandom_range(0, 12));
                p[8*k +: 8] = v[8] ? 8'hFF : v[7:0];
            end else if (style == 2) begin
                p[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        end
        return p;
    endfunction

    // Send one pixel word; entered and left at a falling edge.
    task automatic send_word(input dmlf_pkg::t_pixel pix, input logic eol, input logic eof);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            pix_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        pix_valid = 1'b1;
        pix_data  = pix;
        pix_eol   = eol;
        pix_eof   = eof;
        do @(posedge clk); while (!pix_ready);
        @(negedge clk);
        // Track how far each line store has been written since reset.
        if (row_at[0]) begin
            if (col_at + 1 > odd_cover) odd_cover = col_at + 1;
        end else begin
            if (col_at + 1 > even_cover) even_cover = col_at + 1;
        end
        if (eof) begin
            col_at = '0;
            row_at = '0;
            frames_sent++;
        end else if (eol) begin
            col_at = '0;
            row_at = row_at + 1'b1;
        end else begin
            col_at = col_at + 1'b1;
        end
        words_sent++;
    endtask

    // One row; the frame's last row carries the end-of-frame mark, end of line at random.
    task automatic send_row(input int len, input logic closes_frame, input int style,
                            input dmlf_pkg::t_pixel base);
        logic tail_eol;
        tail_eol = closes_frame ? 1'($urandom_range(0, 1)) : 1'b1;
        for (int i = 0; i < len; i++)
            send_word(make_pixel(style, base), (i == len - 1) && tail_eol,
                      (i == len - 1) && closes_frame);
    endtask

    // Wait until every predicted rewrite has arrived and the pipeline is empty.
    task automatic settle();
        pix_valid = 1'b0;
        do begin
            while (rewrites_left != 0) @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end while (rewrites_left != 0);
    endtask

    task automatic write_mode(input dmlf_pkg::t_mode m);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = m;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        mode_writes++;
    endtask

    // A random frame; no row reads a store entry that was never written.
    task automatic send_frame();
        int               n_rows;
        int               width;
        int               len;
        int               room;
        int               style;
        dmlf_pkg::t_pixel base;
        n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        width  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        style  = $urandom_range(0, 3);
        if (style == 3) style = 1;
        base   = dmlf_pkg::t_pixel'($urandom());
        for (int r = 0; r < n_rows; r++) begin
            if (r != 0 && $urandom_range(0, 15) == 0)
                write_mode(dmlf_pkg::t_mode'($urandom_range(0, 2)));
            if (row_at[0])
                room = even_cover;
            else if (row_at >= 2)
                room = (odd_cover + 1 < even_cover) ? odd_cover + 1 : even_cover;
            else
                room = LINE_MAX;
            len = ($urandom_range(0, 3) != 0) ? width : $urandom_range(1, width + 3);
            if (len > room) len = room;
            send_row(len, r == n_rows - 1, style, base);
        end
    endtask

    initial begin
        int random_start;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset mode leaves the frame alone.
        send_word(24'h000000, 1'b0, 1'b0);
        send_word(24'hFFFFFF, 1'b0, 1'b0);
        send_word(24'h123456, 1'b1, 1'b0);
        send_word(24'hFFFFFF, 1'b0, 1'b0);
        send_word(24'h000000, 1'b0, 1'b0);
        send_word(24'hABCDEF, 1'b1, 1'b1);

        // Clamp filter: one pixel far out, one just below in the low byte only, one inside.
        write_mode(dmlf_pkg::MODE_CLAMP);
        send_word(24'h000000, 1'b0, 1'b0);
        send_word(24'h404040, 1'b0, 1'b0);
        send_word(24'h808080, 1'b0, 1'b0);
        send_word(24'hFFFFFF, 1'b0, 1'b0);
        send_word(24'h808080, 1'b1, 1'b0);
        send_word(24'h111111, 1'b0, 1'b0);
        send_word(24'hFFFFFF, 1'b0, 1'b0);
        send_word(24'hA0A07F, 1'b0, 1'b0);
        send_word(24'hC0C0C0, 1'b0, 1'b0);
        send_word(24'h222222, 1'b1, 1'b0);
        send_word(24'h010101, 1'b0, 1'b0);
        send_word(24'h414141, 1'b0, 1'b0);
        send_word(24'h818181, 1'b0, 1'b0);
        send_word(24'hFEFEFE, 1'b0, 1'b0);
        send_word(24'h818181, 1'b1, 1'b1);

        // Line doubling; the frame ends on an odd row with end of frame but no end of line.
        write_mode(dmlf_pkg::MODE_DOUBLE);
        send_word(24'hFFFFFF, 1'b0, 1'b0);
        send_word(24'h000001, 1'b0, 1'b0);
        send_word(24'h800000, 1'b1, 1'b0);
        send_word(24'h000000, 1'b0, 1'b0);
        send_word(24'h000000, 1'b0, 1'b0);
        send_word(24'h7FFFFF, 1'b0, 1'b1);

        // Random frames; the last stretch runs without any idling.
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            if (words_sent - random_start >= CALM_FROM) begin
                src_gap_pct   = 0;
                snk_stall_pct = 0;
            end else begin
                src_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                snk_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end
            write_mode(dmlf_pkg::t_mode'($urandom_range(0, 2)));
            repeat ($urandom_range(1, 3)) send_frame();
        end

        settle();
        if (rewrites_left != 0) $error("%0d predicted rewrites never arrived", rewrites_left);
        $display("Sent %0d pixel words in %0d frames with %0d mode writes,", words_sent,
                 frames_sent, mode_writes);
        $display("covering all three modes under random stalls; %0d rewrites compared.",
                 rewrites_checked);
        if (mismatches == 0 && rewrites_left == 0) begin
            $display("[deinterlace_minmax_line_filter] OK");
        end else begin
            $display("[deinterlace_minmax_line_filter] ERROR");
        end
        $finish;
    end

endmodule

// ===== deinterlace_minmax_line_filter.f =====
hw/rtl/dmlf_pkg.sv
hw/rtl/dmlf_clamp.sv
hw/rtl/deinterlace_minmax_line_filter.sv
hw/rtl/dmlf_checker.sv
tb/sv/dmlf_rewrite_checker.sv
tb/sv/tb_deinterlace_minmax_line_filter.sv
